### rtl/assert_macros.svh
// Assertion helpers shared by the deframer RTL.
// Each helper is a clocked property check, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define WDF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deframer check failed");

`define WDF_ASSERT_NEVER(lbl, clk, rst, cond) \
  `WDF_ASSERT(lbl, clk, rst, !(cond))

`else

`define WDF_ASSERT(lbl, clk, rst, prop)

`define WDF_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

### rtl/wdf_pkg.sv
package wdf_pkg;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Length codes in the second header byte
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic UNMASK_RESET = 1'b1;

  // One result transaction as it travels from front to back
  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [31:0] key_word;
    logic [7:0]  raw_byte;
    logic [1:0]  key_idx;
    logic        apply_mask;
    logic        last;
  } wdf_cmd_t;

endpackage

### rtl/wdf_if.sv
// Input byte channel
interface wdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Result channel
interface wdf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic [31:0] key_word;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, output kind, output fin, output opcode, output masked,
                  output payload_length, output key_word, output data_byte,
                  output last, input ready);
  modport sink (input valid, input kind, input fin, input opcode, input masked,
                input payload_length, input key_word, input data_byte,
                input last, output ready);
endinterface

// Configuration write channel
interface wdf_cfg_if;
  logic valid;
  logic ready;
  logic unmask_enable;

  modport source (output valid, output unmask_enable, input ready);
  modport sink (input valid, input unmask_enable, output ready);
endinterface

### rtl/wdf_front.sv
`include "assert_macros.svh"

module wdf_front import wdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  wdf_in_if.sink   rx,
  wdf_cfg_if.sink  cfg,
  input  logic     q_space,
  output logic     push,
  output wdf_cmd_t push_cmd
);

  localparam logic [2:0] PH_BYTE1   = 3'd0;
  localparam logic [2:0] PH_BYTE2   = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [3:0]  ext_left, ext_left_next;
  logic [63:0] len_acc, len_acc_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] key_reg, key_reg_next;
  logic [1:0]  key_idx, key_idx_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic        unmask_enable;

  logic        accept;
  logic        hdr_done;
  logic        len_done;
  logic        data_out;
  logic        data_last;
  logic [7:0]  b;

  assign rx.ready  = q_space;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.in_byte;

  always_comb begin
    phase_next     = phase;
    ext_left_next  = ext_left;
    len_acc_next   = len_acc;
    remaining_next = remaining;
    key_reg_next   = key_reg;
    key_idx_next   = key_idx;
    fin_next       = fin;
    opcode_next    = opcode;
    masked_next    = masked;
    hdr_done       = 1'b0;
    len_done       = 1'b0;
    data_out       = 1'b0;
    data_last      = 1'b0;

    case (phase)
      PH_BYTE2: begin
        masked_next  = b[7];
        len_acc_next = '0;
        if (b[6:0] == LEN_CODE_16) begin
          ext_left_next = 4'd2;
          phase_next    = PH_EXTLEN;
        end else if (b[6:0] == LEN_CODE_64) begin
          ext_left_next = 4'd8;
          phase_next    = PH_EXTLEN;
        end else begin
          len_acc_next = {57'd0, b[6:0]};
          len_done     = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_acc_next  = {len_acc[55:0], b};
        ext_left_next = ext_left - 4'd1;
        len_done      = (ext_left_next == 4'd0);
      end
      PH_KEY: begin
        key_reg_next = {key_reg[23:0], b};
        if (key_idx == 2'd3) begin
          hdr_done = 1'b1;
        end else begin
          key_idx_next = key_idx + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        key_idx_next   = key_idx + 2'd1;
        remaining_next = remaining - 64'd1;
        data_out       = 1'b1;
        data_last      = (remaining_next == 64'd0);
        if (data_last) begin
          phase_next = PH_BYTE1;
        end
      end
      default: begin
        fin_next       = b[7];
        opcode_next    = b[3:0];
        masked_next    = 1'b0;
        key_reg_next   = '0;
        key_idx_next   = '0;
        ext_left_next  = '0;
        len_acc_next   = '0;
        remaining_next = '0;
        phase_next     = PH_BYTE2;
      end
    endcase

    // Length known: collect the key or close out the header
    if (len_done) begin
      if (masked_next) begin
        key_idx_next = '0;
        key_reg_next = '0;
        phase_next   = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      key_idx_next = '0;
      if (len_acc_next == 64'd0) begin
        phase_next = PH_BYTE1;
      end else begin
        remaining_next = len_acc_next;
        phase_next     = PH_PAYLOAD;
      end
    end
  end

  always_comb begin
    push                    = accept && (hdr_done || data_out);
    push_cmd.kind           = data_out ? KIND_DATA : KIND_HEADER;
    push_cmd.fin            = fin_next;
    push_cmd.opcode         = opcode_next;
    push_cmd.masked         = masked_next;
    push_cmd.payload_length = len_acc_next;
    push_cmd.key_word       = key_reg_next;
    push_cmd.raw_byte       = data_out ? b : 8'd0;
    push_cmd.key_idx        = key_idx;
    push_cmd.apply_mask     = data_out && masked && unmask_enable;
    push_cmd.last           = data_out ? data_last : (len_acc_next == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_BYTE1;
      ext_left      <= '0;
      len_acc       <= '0;
      remaining     <= '0;
      key_reg       <= '0;
      key_idx       <= '0;
      fin           <= 1'b0;
      opcode        <= '0;
      masked        <= 1'b0;
      unmask_enable <= UNMASK_RESET;
    end else begin
      if (cfg.valid) begin
        unmask_enable <= cfg.unmask_enable;
      end
      if (accept) begin
        phase     <= phase_next;
        ext_left  <= ext_left_next;
        len_acc   <= len_acc_next;
        remaining <= remaining_next;
        key_reg   <= key_reg_next;
        key_idx   <= key_idx_next;
        fin       <= fin_next;
        opcode    <= opcode_next;
        masked    <= masked_next;
      end
    end
  end

  `WDF_ASSERT(a_payload_nonzero, clk, rst, (phase == PH_PAYLOAD) |-> (remaining != 64'd0))
  `WDF_ASSERT(a_payload_pushes, clk, rst, (accept && phase == PH_PAYLOAD) |-> push)
  `WDF_ASSERT_NEVER(a_push_no_space, clk, rst, push && !q_space)

endmodule

### rtl/wdf_queue.sv
`include "assert_macros.svh"

module wdf_queue import wdf_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  wdf_cmd_t push_cmd,
  output logic     space,
  input  logic     pop,
  output logic     avail,
  output wdf_cmd_t head
);

  localparam int PTR_W = $clog2(Depth);
  localparam int CNT_W = $clog2(Depth + 1);

  wdf_cmd_t entries [Depth];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign space = (count != CNT_W'(Depth));
  assign avail = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Depth - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Depth - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `WDF_ASSERT_NEVER(a_pop_empty, clk, rst, pop && !avail)
  `WDF_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(Depth))
  `WDF_ASSERT(a_ptr_track, clk, rst, (count == '0) |-> (wr_ptr == rd_ptr))

endmodule

### rtl/wdf_back.sv
`include "assert_macros.svh"

module wdf_back import wdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       avail,
  input  wdf_cmd_t   head,
  output logic       pop,
  wdf_out_if.source  tx
);

  logic        out_valid;
  wdf_cmd_t    out_cmd;
  logic [7:0]  out_data;
  logic [7:0]  key_byte;

  assign pop = avail && (!out_valid || tx.ready);

  // Pick the key byte for this payload position, first key byte at index zero
  always_comb begin
    case (head.key_idx)
      2'd0:    key_byte = head.key_word[31:24];
      2'd1:    key_byte = head.key_word[23:16];
      2'd2:    key_byte = head.key_word[15:8];
      default: key_byte = head.key_word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_cmd  <= head;
      out_data <= head.apply_mask ? (head.raw_byte ^ key_byte) : head.raw_byte;
    end
  end

  assign tx.valid          = out_valid;
  assign tx.kind           = out_cmd.kind;
  assign tx.fin            = out_cmd.fin;
  assign tx.opcode         = out_cmd.opcode;
  assign tx.masked         = out_cmd.masked;
  assign tx.payload_length = out_cmd.payload_length;
  assign tx.key_word       = out_cmd.key_word;
  assign tx.data_byte      = out_data;
  assign tx.last           = out_cmd.last;

  `WDF_ASSERT(a_load_shows, clk, rst, pop |=> out_valid)
  `WDF_ASSERT_NEVER(a_hdr_data, clk, rst, out_valid && out_cmd.kind == KIND_HEADER && |out_data)
  `WDF_ASSERT(a_hold, clk, rst, (out_valid && !tx.ready) |=> out_valid && $stable(out_data))

endmodule

### rtl/websocket_frame_deframer.sv
// WebSocket (RFC 6455) frame deframer. Feed the received stream one byte per rx transaction;
// the block parses FIN/opcode, the MASK bit, the 7-bit, 16-bit or 64-bit big-endian length and
// the optional 4-byte mask key (RSV bits are ignored), then emits one header transaction
// (kind 0, last set when the frame is empty) followed by one tx transaction per payload byte
// (kind 1), XORed with the rotating key byte when the frame is masked and unmask_enable is 1;
// last marks the final payload byte. Header bytes themselves produce no tx transaction. Every
// result repeats the current frame's fin, opcode, masked, payload_length and key_word
// (key_word zero for unmasked frames). Throughput is one byte per clock cycle sustained: the
// parser takes a byte every cycle while the command queue has room, and the output register
// drains one entry per cycle while tx.ready is high. Each result is written into a queue entry
// when its byte is accepted and then loaded into the output register before it is presented on
// tx; with QueueDepth entries of queue plus the output register, up to QueueDepth + 1 results
// may wait on a stalled tx before rx.ready drops.
// Write unmask_enable (reset value 1) through cfg only while no frame data is in flight.
module websocket_frame_deframer import wdf_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  wdf_in_if.sink    rx,
  wdf_out_if.source tx,
  wdf_cfg_if.sink   cfg
);

  // Front to queue
  logic     push;
  wdf_cmd_t push_cmd;
  logic     q_space;

  // Queue to back
  logic     pop;
  logic     q_avail;
  wdf_cmd_t q_head;

  // Parse header bytes, track the frame and classify each byte
  wdf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .cfg      (cfg),
    .q_space  (q_space),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple parsing from output backpressure
  wdf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .space    (q_space),
    .pop      (pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  // Unmask payload bytes and hold each result until tx takes it
  wdf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (q_avail),
    .head  (q_head),
    .pop   (pop),
    .tx    (tx)
  );

endmodule

### tb/deframer_checker.sv
`timescale 1ns / 100ps

module deframer_checker import wdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  wdf_in_if    rx,
  wdf_out_if   tx,
  wdf_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output logic frame_idle
);

  typedef enum logic [2:0] {
    PH_FLAGS,
    PH_LEN,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } parse_phase_e;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [31:0] key_word;
    logic [7:0]  data_byte;
    logic        last;
  } deframed_t;

  parse_phase_e phase;
  logic [3:0]   ext_left;
  logic [63:0]  length_acc;
  logic [63:0]  bytes_left;
  logic [31:0]  key;
  logic [1:0]   key_pos;
  logic         hdr_fin;
  logic [3:0]   hdr_op;
  logic         hdr_mask;
  logic         unmask;
  deframed_t    results_due[$];

  task automatic push_result(input logic kind, input logic [7:0] data, input logic last);
    deframed_t r;
    r.kind           = kind;
    r.fin            = hdr_fin;
    r.opcode         = hdr_op;
    r.masked         = hdr_mask;
    r.payload_length = length_acc;
    r.key_word       = key;
    r.data_byte      = data;
    r.last           = last;
    results_due.push_back(r);
  endtask

  task automatic close_header();
    key_pos = '0;
    if (length_acc == '0) begin
      push_result(KIND_HEADER, 8'h00, 1'b1);
      phase = PH_FLAGS;
    end else begin
      push_result(KIND_HEADER, 8'h00, 1'b0);
      bytes_left = length_acc;
      phase = PH_DATA;
    end
  endtask

  // Length known: collect the key first when the frame is masked.
  task automatic close_length();
    if (hdr_mask) begin
      key_pos = '0;
      key = '0;
      phase = PH_KEY;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] data;
    case (phase)
      PH_LEN: begin
        hdr_mask = b[7];
        length_acc = '0;
        if (b[6:0] == LEN_CODE_16) begin
          ext_left = 4'd2;
          phase = PH_EXT;
        end else if (b[6:0] == LEN_CODE_64) begin
          ext_left = 4'd8;
          phase = PH_EXT;
        end else begin
          length_acc = {57'd0, b[6:0]};
          close_length();
        end
      end
      PH_EXT: begin
        length_acc = {length_acc[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == '0) close_length();
      end
      PH_KEY: begin
        key = {key[23:0], b};
        if (key_pos == 2'd3) close_header();
        else key_pos = key_pos + 2'd1;
      end
      PH_DATA: begin
        data = b;
        if (hdr_mask && unmask) data = data ^ key[8 * (3 - key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        bytes_left = bytes_left - 64'd1;
        if (bytes_left == '0) begin
          push_result(KIND_DATA, data, 1'b1);
          phase = PH_FLAGS;
        end else begin
          push_result(KIND_DATA, data, 1'b0);
        end
      end
      default: begin
        hdr_fin    = b[7];
        hdr_op     = b[3:0];
        hdr_mask   = 1'b0;
        key        = '0;
        key_pos    = '0;
        ext_left   = '0;
        length_acc = '0;
        bytes_left = '0;
        phase      = PH_LEN;
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    deframed_t want;
    if (rst) begin
      phase      = PH_FLAGS;
      ext_left   = '0;
      length_acc = '0;
      bytes_left = '0;
      key        = '0;
      key_pos    = '0;
      hdr_fin    = 1'b0;
      hdr_op     = '0;
      hdr_mask   = 1'b0;
      unmask     = UNMASK_RESET;
      results_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) unmask = cfg.unmask_enable;
      if (rx.valid && rx.ready) deframe_byte(rx.in_byte);
      if (tx.valid && tx.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got kind %b data %h",
                   $time, tx.kind, tx.data_byte);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", 64'(want.kind), 64'(tx.kind));
          check_field("fin", 64'(want.fin), 64'(tx.fin));
          check_field("opcode", 64'(want.opcode), 64'(tx.opcode));
          check_field("masked", 64'(want.masked), 64'(tx.masked));
          check_field("payload_length", want.payload_length, tx.payload_length);
          check_field("key_word", 64'(want.key_word), 64'(tx.key_word));
          check_field("data_byte", 64'(want.data_byte), 64'(tx.data_byte));
          check_field("last", 64'(want.last), 64'(tx.last));
        end
      end
    end
    pending    = results_due.size();
    frame_idle = (phase == PH_FLAGS);
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb import wdf_pkg::*; ();

  // Cycles without any transaction on rx, tx or cfg before the run is declared hung.
  // The longest legal quiet stretch is a sender gap plus a receiver stall plus the
  // hold-off before a register write, well under this.
  localparam int QUIET_LIMIT = 2000;
  localparam int WIDTH_7     = 7;
  localparam int WIDTH_16    = 16;
  localparam int WIDTH_64    = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wdf_in_if  rx ();
  wdf_out_if tx ();
  wdf_cfg_if cfg ();

  int   fail_count;
  int   pending;
  logic frame_idle;

  // Idle chance in percent per byte (sender) and per cycle (receiver).
  int send_pct   = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int quiet      = 0;
  int bytes_sent = 0;

  logic [7:0] wire_bytes[$];

  always #5 clk = ~clk;

  websocket_frame_deframer DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .tx  (tx),
    .cfg (cfg)
  );

  deframer_checker frame_check (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .tx         (tx),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending),
    .frame_idle (frame_idle)
  );

  // Receiver: stall tx in bursts of random length while stalling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      tx.ready = 1'b0;
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      tx.ready = 1'b0;
      stall_left = $urandom_range(16);
    end else begin
      tx.ready = 1'b1;
    end
  end

  // Watchdog: count cycles in which no transaction completes anywhere.
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (tx.valid && tx.ready) || (cfg.valid && cfg.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Drive one byte at the falling edge and hold it until rx takes it. Leave valid
  // high on return so back-to-back bytes never drop valid in between.
  task automatic send_byte(input logic [7:0] b);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      rx.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    rx.valid   = 1'b1;
    rx.in_byte = b;
    do @(posedge clk); while (!rx.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic flush_bytes();
    while (wire_bytes.size() > 0) send_byte(wire_bytes.pop_front());
  endtask

  // Append one frame: first header byte as given, length in the requested width,
  // key when masked, then body random payload bytes (body may fall short of length).
  task automatic queue_frame(input logic [7:0] b0, input logic masked, input logic [31:0] key,
                             input int width, input logic [63:0] length, input int body);
    wire_bytes.push_back(b0);
    case (width)
      WIDTH_16: begin
        wire_bytes.push_back({masked, LEN_CODE_16});
        wire_bytes.push_back(length[15:8]);
        wire_bytes.push_back(length[7:0]);
      end
      WIDTH_64: begin
        wire_bytes.push_back({masked, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) wire_bytes.push_back(length[8 * i +: 8]);
      end
      default: begin
        wire_bytes.push_back({masked, length[6:0]});
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) wire_bytes.push_back(key[8 * i +: 8]);
    repeat (body) wire_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Mostly short payloads; a few at the 7-bit maximum and a few 16-bit lengths past it.
  // Extended widths also carry small, non-minimal lengths, zero among them.
  task automatic queue_random_frame();
    int         pick;
    int         width;
    logic [63:0] length;
    pick = $urandom_range(99);
    if (pick < 50) begin
      width = WIDTH_7;
      length = 64'($urandom_range(12));
    end else if (pick < 62) begin
      width = WIDTH_7;
      length = 64'($urandom_range(125));
    end else if (pick < 66) begin
      width = WIDTH_7;
      length = 64'd125;
    end else if (pick < 80) begin
      width = WIDTH_16;
      length = 64'($urandom_range(20));
    end else if (pick < 86) begin
      width = WIDTH_16;
      length = 64'($urandom_range(126, 300));
    end else begin
      width = WIDTH_64;
      length = 64'($urandom_range(20));
    end
    queue_frame(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom(), width, length,
                int'(length));
  endtask

  task automatic pick_idling();
    int pick;
    pick = $urandom_range(3);
    send_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 20 : 40;
    pick = $urandom_range(3);
    stall_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 20 : 40;
  endtask

  // Random traffic: well-formed frames, and now and then a frame cut short. After
  // a cut, feed zero bytes until the parser is back at a frame boundary; zeros
  // only shrink lengths, so the resync is short.
  task automatic run_traffic(input int budget, input logic idling);
    int stop_at;
    int keep;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      if (idling) pick_idling();
      queue_random_frame();
      if ($urandom_range(99) < 12 && wire_bytes.size() > 1) begin
        keep = $urandom_range(1, wire_bytes.size() - 1);
        while (wire_bytes.size() > keep) void'(wire_bytes.pop_back());
        flush_bytes();
        while (!frame_idle) send_byte(8'h00);
      end else begin
        flush_bytes();
      end
    end
  endtask

  // Write the unmask register with the block idle: drop rx, drain every expected
  // result, let header bytes still in the pipe settle, then do the transaction.
  task automatic write_unmask(input logic value);
    rx.valid = 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
    cfg.unmask_enable = value;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  initial begin
    rx.valid          = 1'b0;
    rx.in_byte        = 8'h00;
    cfg.valid         = 1'b0;
    cfg.unmask_enable = 1'b0;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed frames, unmasking on from reset.
    // Empty unmasked frame, FIN set, continuation opcode.
    queue_frame(8'h80, 1'b0, 32'h0, WIDTH_7, 64'd0, 0);
    // Empty masked frame, RSV bits and all opcode bits set, FIN clear.
    queue_frame(8'h7F, 1'b1, 32'hFFFF_FFFF, WIDTH_7, 64'd0, 0);
    // Masked payload longer than the key, so the key byte wraps.
    queue_frame(8'h89, 1'b1, 32'h0102_0304, WIDTH_7, 64'd5, 5);
    // 16-bit length of zero, then a non-minimal 16-bit length.
    queue_frame(8'h02, 1'b0, 32'h0, WIDTH_16, 64'd0, 0);
    queue_frame(8'h81, 1'b0, 32'h0, WIDTH_16, 64'd2, 2);
    // 64-bit length of zero on a masked frame: key, then empty header.
    queue_frame(8'h01, 1'b1, 32'hA5A5_5A5A, WIDTH_64, 64'd0, 0);
    // Non-minimal 64-bit length with a payload.
    queue_frame(8'h8A, 1'b0, 32'h0, WIDTH_64, 64'd3, 3);
    // Largest 7-bit length.
    queue_frame(8'h88, 1'b1, 32'h8000_0001, WIDTH_7, 64'd125, 125);
    flush_bytes();

    run_traffic(330, 1'b1);

    // Pass masked payloads through untouched.
    write_unmask(1'b0);
    queue_frame(8'h82, 1'b1, 32'hDEAD_BEEF, WIDTH_7, 64'd6, 6);
    flush_bytes();
    run_traffic(330, 1'b1);

    write_unmask(1'b1);
    run_traffic(300, 1'b1);

    // Last part: no idling on either side.
    send_pct  = 0;
    stall_pct = 0;
    write_unmask(1'b0);
    run_traffic(180, 1'b0);

    // Largest 64-bit length, top bit set; the frame never completes, so it goes last.
    queue_frame(8'h82, 1'b1, 32'h1234_5678, WIDTH_64, 64'hFFFF_FFFF_FFFF_FFFF, 12);
    flush_bytes();

    rx.valid = 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
